/* rtl/core/lpht_pkg.sv */
// Package for the linear-probing hash table: widths, status and request codes,
// controller state type and key character constants. Depends on nothing.
package lpht_pkg;

   localparam int TABLE_SLOTS_DEF = 26;
   localparam int KEY_W           = 64;
   localparam int VALUE_W         = 64;
   localparam int REQ_W           = 2;
   localparam int STATUS_W        = 3;
   localparam int CHAR_W          = 8;

   localparam logic [REQ_W-1:0] REQ_INSERT   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_SEARCH   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DELETE   = 2'd2;
   localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

   localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REPLACED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_BAD_KEY   = 3'd6;

   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

   typedef enum logic [1:0] {
      S_IDLE,
      S_INSERT,
      S_SEARCH,
      S_RESP
   } lpht_state_type;

endpackage

/* rtl/core/lpht_ifs.sv */
// Valid/ready channel interfaces of the hash table: request, response and
// configuration write. Depends on lpht_pkg.
interface lpht_req_if import lpht_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [REQ_W-1:0]   req_type;
   logic [KEY_W-1:0]   key;
   logic [VALUE_W-1:0] value;

   modport source (output valid, req_type, key, value, input ready);
   modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface lpht_rsp_if import lpht_pkg::*; #(
   parameter int SLOT_W = $clog2(TABLE_SLOTS_DEF)
) ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [VALUE_W-1:0]  found_value;
   logic [SLOT_W-1:0]   slot;

   modport source (output valid, status, found_value, slot, input ready);
   modport sink   (input valid, status, found_value, slot, output ready);
endinterface

interface lpht_csr_if ();
   logic valid;
   logic ready;
   logic replace_mode;

   modport source (output valid, replace_mode, input ready);
   modport sink   (input valid, replace_mode, output ready);
endinterface

/* rtl/core/lpht_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module lpht_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 26
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/linear_probe_hash_table.sv */
// A bad key or reserved request goes straight to the result state. An insert probes
// up to TABLE_SLOTS slots for a free one; a search or delete reads up to TABLE_SLOTS slots.
// One slot is probed per cycle: the occupancy bits for insert, the key RAM read port
// (one read issued and one compared each cycle) for search and delete.
// One request is in service at a time; the next is accepted while a result waits.
// Synchronous reset empties the table at once and clears replace_mode; no clearing pass.
module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lpht_req_if.sink   req_chan,
   lpht_rsp_if.source rsp_chan,
   lpht_csr_if.sink   csr_chan
);

   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

   lpht_state_type state_ff, state_in;

   logic [REQ_W-1:0]       req_type_ff, req_type_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [VALUE_W-1:0]     value_ff, value_in;
   logic [SLOT_W-1:0]      idx_ff, idx_in;
   logic [SLOT_W-1:0]      cnt_ff, cnt_in;
   logic                   pend_ff, pend_in;
   logic [SLOT_W-1:0]      pend_idx_ff, pend_idx_in;
   logic                   issued_all_ff, issued_all_in;
   logic [TABLE_SLOTS-1:0] occ_ff, occ_in;
   logic                   replace_ff;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [VALUE_W-1:0]     res_fv_ff, res_fv_in;
   logic [SLOT_W-1:0]      res_slot_ff, res_slot_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [VALUE_W-1:0]     rsp_fv_ff;
   logic [SLOT_W-1:0]      rsp_slot_ff;

   logic                   ram_we;
   logic                   ram_re;
   logic                   rsp_load;
   logic [KEY_W-1:0]       key_rd;
   logic [VALUE_W-1:0]     value_rd;
   logic [CHAR_W-1:0]      first_char;
   logic                   is_lower;
   logic                   is_upper;
   logic [SLOT_W-1:0]      home;
   logic [SLOT_W-1:0]      idx_next;

   lpht_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SLOTS)) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (key_ff),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (key_rd)
   );

   lpht_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_SLOTS)) u_value_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (value_ff),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (value_rd)
   );

   assign first_char = req_chan.key[KEY_W-1 -: CHAR_W];
   assign is_lower   = (first_char >= CHAR_LOWER_A) && (first_char <= CHAR_LOWER_Z);
   assign is_upper   = (first_char >= CHAR_UPPER_A) && (first_char <= CHAR_UPPER_Z);
   assign home       = is_lower ? SLOT_W'(first_char - CHAR_LOWER_A)
                                : SLOT_W'(first_char - CHAR_UPPER_A);
   assign idx_next   = (idx_ff == LAST_SLOT) ? '0 : idx_ff + SLOT_W'(1);

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_load       = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_valid_in   = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

   always_comb begin
      state_in      = state_ff;
      req_type_in   = req_type_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      issued_all_in = issued_all_ff;
      occ_in        = occ_ff;
      res_status_in = res_status_ff;
      res_fv_in     = res_fv_ff;
      res_slot_in   = res_slot_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               req_type_in   = req_chan.req_type;
               key_in        = req_chan.key;
               value_in      = req_chan.value;
               idx_in        = home;
               cnt_in        = '0;
               issued_all_in = 1'b0;
               res_fv_in     = '0;
               res_slot_in   = '0;
               if (req_chan.req_type == REQ_RESERVED) begin
                  res_status_in = ST_NOT_FOUND;
                  state_in      = S_RESP;
               end else if (!is_lower && !is_upper) begin
                  res_status_in = ST_BAD_KEY;
                  state_in      = S_RESP;
               end else if (req_chan.req_type == REQ_INSERT) begin
                  state_in = S_INSERT;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_INSERT: begin
            if (cnt_ff == '0 && replace_ff && occ_ff[idx_ff]) begin
               ram_we        = 1'b1;
               res_status_in = ST_REPLACED;
               res_slot_in   = idx_ff;
               state_in      = S_RESP;
            end else if (!occ_ff[idx_ff]) begin
               ram_we         = 1'b1;
               occ_in[idx_ff] = 1'b1;
               res_status_in  = ST_ADDED;
               res_slot_in    = idx_ff;
               state_in       = S_RESP;
            end else if (cnt_ff == LAST_SLOT) begin
               res_status_in = ST_FULL;
               state_in      = S_RESP;
            end else begin
               idx_in = idx_next;
               cnt_in = cnt_ff + SLOT_W'(1);
            end
         end
         S_SEARCH: begin
            // The slot read last cycle is compared before the next one is issued,
            // so a match earlier in the chain always wins.
            if (pend_ff && key_rd == key_ff) begin
               res_slot_in = pend_idx_ff;
               state_in    = S_RESP;
               if (req_type_ff == REQ_SEARCH) begin
                  res_status_in = ST_FOUND;
                  res_fv_in     = value_rd;
               end else begin
                  res_status_in       = ST_DELETED;
                  occ_in[pend_idx_ff] = 1'b0;
               end
            end else if (issued_all_ff || !occ_ff[idx_ff]) begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_RESP;
            end else begin
               ram_re        = 1'b1;
               pend_in       = 1'b1;
               pend_idx_in   = idx_ff;
               idx_in        = idx_next;
               cnt_in        = cnt_ff + SLOT_W'(1);
               issued_all_in = (cnt_ff == LAST_SLOT);
            end
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         occ_ff       <= '0;
         replace_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            replace_ff <= csr_chan.replace_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff   <= req_type_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      pend_idx_ff   <= pend_idx_in;
      issued_all_ff <= issued_all_in;
      res_status_ff <= res_status_in;
      res_fv_ff     <= res_fv_in;
      res_slot_ff   <= res_slot_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_fv_ff     <= res_fv_ff;
         rsp_slot_ff   <= res_slot_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.found_value = rsp_fv_ff;
   assign rsp_chan.slot        = rsp_slot_ff;

`ifndef NO_ASSERTIONS
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("response raised outside the result state");

   a_occ_one_bit: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> $countones(occ_ff ^ $past(occ_ff)) <= 1)
      else $error("more than one occupancy bit changed in a cycle");

   a_write_in_insert: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == S_INSERT && !occ_ff[idx_ff] || replace_ff)
      else $error("table write outside an insert");

   a_no_pend_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_ff)
      else $error("probe read outstanding while idle");
`endif

endmodule

/* sim/tb_linear_probe_hash_table.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the linear-probing hash table: drives insert, search and
// delete requests and compares every response against a shadow copy of the table.
// Depends on lpht_pkg, the channel interfaces in lpht_ifs.sv and the table RTL.
module tb_linear_probe_hash_table;
   import lpht_pkg::*;

   localparam int SLOTS  = TABLE_SLOTS_DEF;
   localparam int SLOT_W = $clog2(TABLE_SLOTS_DEF);

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  found_value;
      logic [SLOT_W-1:0]   slot;
   } table_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lpht_req_if req_chan ();
   lpht_rsp_if rsp_chan ();
   lpht_csr_if csr_chan ();

   linear_probe_hash_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Shadow of the table contents and of the mode register.
   logic [KEY_W-1:0]   shadow_keys [SLOTS];
   logic [VALUE_W-1:0] shadow_values [SLOTS];
   logic [SLOTS-1:0]   shadow_used;
   logic               shadow_replace;

   table_answer_type pending_answers [$];
   table_answer_type oldest_answer;
   logic [KEY_W-1:0] key_pool [20];

   int error_count   = 0;
   int request_count = 0;
   int mode_writes   = 0;
   int status_seen [8];
   int unsigned rsp_hold = 0;
   bit idling_on = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic table_answer_type predict_answer(input logic [REQ_W-1:0] op,
                                                       input logic [KEY_W-1:0] key,
                                                       input logic [VALUE_W-1:0] val);
      table_answer_type ans;
      logic [CHAR_W-1:0] lead;
      int home;
      int s;
      int n;
      ans.status      = ST_NOT_FOUND;
      ans.found_value = '0;
      ans.slot        = '0;
      lead = key[KEY_W-1 -: CHAR_W];
      if (op == REQ_RESERVED) return ans;
      if (lead >= CHAR_LOWER_A && lead <= CHAR_LOWER_Z) begin
         home = int'(lead - CHAR_LOWER_A);
      end else if (lead >= CHAR_UPPER_A && lead <= CHAR_UPPER_Z) begin
         home = int'(lead - CHAR_UPPER_A);
      end else begin
         ans.status = ST_BAD_KEY;
         return ans;
      end
      s = home;
      n = 0;
      if (op == REQ_INSERT) begin
         if (shadow_replace && shadow_used[home]) begin
            shadow_keys[home]   = key;
            shadow_values[home] = val;
            ans.status = ST_REPLACED;
            ans.slot   = SLOT_W'(home);
         end else begin
            while (n < SLOTS && shadow_used[s]) begin
               s = (s + 1) % SLOTS;
               n++;
            end
            if (n < SLOTS) begin
               shadow_keys[s]   = key;
               shadow_values[s] = val;
               shadow_used[s]   = 1'b1;
               ans.status = ST_ADDED;
               ans.slot   = SLOT_W'(s);
            end else begin
               ans.status = ST_FULL;
            end
         end
      end else begin
         // Search and delete stop at the first free slot, the key, or a full lap.
         while (n < SLOTS && shadow_used[s] && shadow_keys[s] != key) begin
            s = (s + 1) % SLOTS;
            n++;
         end
         if (n < SLOTS && shadow_used[s]) begin
            ans.slot = SLOT_W'(s);
            if (op == REQ_SEARCH) begin
               ans.status      = ST_FOUND;
               ans.found_value = shadow_values[s];
            end else begin
               ans.status     = ST_DELETED;
               shadow_used[s] = 1'b0;
            end
         end
      end
      return ans;
   endfunction

   function automatic logic [KEY_W-1:0] make_key(input logic [CHAR_W-1:0] lead,
                                                 input int len);
      logic [KEY_W-1:0] key;
      key = {$urandom, $urandom};
      key[KEY_W-1 -: CHAR_W] = lead;
      return key & ({KEY_W{1'b1}} << (CHAR_W * (8 - len)));
   endfunction

   function automatic logic [CHAR_W-1:0] letter(input int idx, input bit upper);
      return (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_W'(idx % SLOTS);
   endfunction

   function automatic int random_length();
      return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 7)) : 8;
   endfunction

   // Valid stays high from one request to the next unless a gap is inserted.
   task automatic send_request(input logic [REQ_W-1:0] op, input logic [KEY_W-1:0] key,
                               input logic [VALUE_W-1:0] val);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= op;
      req_chan.key      <= key;
      req_chan.value    <= val;
      do @(posedge clock); while (!req_chan.ready);
      pending_answers.push_back(predict_answer(op, key, val));
      request_count++;
   endtask

   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic write_replace_mode(input logic mode);
      wait_for_drain();
      csr_chan.valid        <= 1'b1;
      csr_chan.replace_mode <= mode;
      do @(posedge clock); while (!csr_chan.ready);
      shadow_replace = mode;
      mode_writes++;
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Hand-picked keys around the letter boundaries, wrap-around and broken chains.
   task automatic test_directed();
      logic [KEY_W-1:0] k_apple;
      logic [KEY_W-1:0] k_avocado;
      logic [KEY_W-1:0] k_zebra;
      logic [KEY_W-1:0] k_zulu;
      logic [KEY_W-1:0] k_wide;
      k_apple   = {"apple", 24'h0};
      k_avocado = {"Avocado", 8'h0};
      k_zebra   = {"zebra", 24'h0};
      k_zulu    = {"Zulu", 32'h0};
      k_wide    = {CHAR_LOWER_A + 8'd1, 56'hFF_FFFF_FFFF_FFFF};
      send_request(REQ_SEARCH, k_apple, '0);
      send_request(REQ_DELETE, k_apple, '1);
      send_request(REQ_INSERT, k_apple, 64'h0123_4567_89AB_CDEF);
      send_request(REQ_INSERT, k_avocado, 64'hFEDC_BA98_7654_3210);
      send_request(REQ_SEARCH, k_avocado, '0);
      send_request(REQ_SEARCH, {"avocado", 8'h0}, '0);
      send_request(REQ_INSERT, k_zebra, '1);
      send_request(REQ_INSERT, k_zulu, '0);
      send_request(REQ_SEARCH, k_zulu, '0);
      send_request(REQ_DELETE, k_apple, '0);
      send_request(REQ_SEARCH, k_avocado, '0);
      send_request(REQ_SEARCH, k_zulu, '0);
      send_request(REQ_INSERT, k_wide, '1);
      send_request(REQ_SEARCH, k_wide, '0);
      send_request(REQ_INSERT, '0, '1);
      send_request(REQ_SEARCH, '1, '1);
      send_request(REQ_DELETE, {CHAR_UPPER_A - 8'd1, 56'h0}, '0);
      send_request(REQ_INSERT, {CHAR_UPPER_Z + 8'd1, 56'h41_4243_4445_4647}, '1);
      send_request(REQ_SEARCH, {CHAR_LOWER_A - 8'd1, 56'h0}, '0);
      send_request(REQ_DELETE, {CHAR_LOWER_Z + 8'd1, 56'h0}, '0);
      send_request(REQ_RESERVED, k_zebra, '1);
      send_request(REQ_RESERVED, '0, '0);
      send_request(REQ_DELETE, k_zebra, '0);
      send_request(REQ_SEARCH, {"Z", 56'h0}, '0);
   endtask

   // Fill every slot, push past capacity, then search for absent keys and for one stored key.
   task automatic test_fill_to_capacity();
      int n;
      write_replace_mode(1'b0);
      n = 0;
      while (shadow_used != {SLOTS{1'b1}} && n < 40) begin
         send_request(REQ_INSERT, make_key(letter($urandom_range(0, 25),
                                                  1'($urandom_range(0, 1))),
                                           random_length()), {$urandom, $urandom});
         n++;
      end
      repeat (3) send_request(REQ_INSERT, make_key(letter($urandom_range(0, 25), 1'b0), 8),
                              {$urandom, $urandom});
      repeat (2) send_request(REQ_SEARCH, make_key(letter($urandom_range(0, 25), 1'b1), 8), '0);
      send_request(REQ_SEARCH, shadow_keys[$urandom_range(0, SLOTS - 1)], '0);
   endtask

   task automatic test_replace_mode();
      logic [KEY_W-1:0] fresh;
      write_replace_mode(1'b1);
      send_request(REQ_INSERT, make_key(letter(7, 1'b1), 8), {$urandom, $urandom});
      send_request(REQ_SEARCH, make_key(letter(7, 1'b0), 8), '0);
      send_request(REQ_DELETE, shadow_keys[12], '0);
      fresh = make_key(letter(12, 1'b0), 5);
      send_request(REQ_INSERT, fresh, {$urandom, $urandom});
      send_request(REQ_SEARCH, fresh, '0);
      send_request(REQ_INSERT, make_key(letter(12, 1'b1), 8), '1);
      send_request(REQ_SEARCH, fresh, '0);
      send_request(REQ_INSERT, make_key(letter(25, 1'b0), 8), '0);
   endtask

   // Mixed traffic around a small window of home slots so that chains form and break.
   task automatic test_random_traffic(input int items, input logic mode, input bit gaps);
      int base;
      int span;
      int insert_weight;
      int pick;
      int s;
      logic [REQ_W-1:0] op;
      logic [KEY_W-1:0] key;
      write_replace_mode(mode);
      idling_on = gaps;
      base = $urandom_range(0, 25);
      span = $urandom_range(1, 6);
      insert_weight = $urandom_range(25, 55);
      foreach (key_pool[i])
         key_pool[i] = make_key(letter(base + $urandom_range(0, span - 1),
                                       1'($urandom_range(0, 1))),
                                random_length());
      for (int i = 0; i < items; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            op  = (pick < 2) ? REQ_RESERVED : REQ_W'($urandom_range(0, 3));
            key = {$urandom, $urandom};
         end else if (pick < 4 + insert_weight) begin
            op  = REQ_INSERT;
            key = ($urandom_range(0, 9) < 6) ? key_pool[$urandom_range(0, 19)]
                  : make_key(letter(base + $urandom_range(0, span - 1),
                                    1'($urandom_range(0, 1))),
                             random_length());
         end else begin
            op = ($urandom_range(0, 99) < 55) ? REQ_SEARCH : REQ_DELETE;
            s  = $urandom_range(0, SLOTS - 1);
            key = (shadow_used[s] && $urandom_range(0, 9) < 7) ? shadow_keys[s]
                  : key_pool[$urandom_range(0, 19)];
            // Flipping the case keeps the home slot but changes the key.
            if ($urandom_range(0, 9) == 0) key[KEY_W-3] = ~key[KEY_W-3];
         end
         send_request(op, key, {$urandom, $urandom});
         if ($urandom_range(0, 79) == 0) wait_for_drain();
      end
   endtask

   always @(posedge clock) begin
      if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected response: status %0d, slot %0d", rsp_chan.status,
                   rsp_chan.slot);
            error_count++;
         end else begin
            oldest_answer = pending_answers.pop_front();
            status_seen[oldest_answer.status]++;
            if (rsp_chan.status !== oldest_answer.status) begin
               $error("status mismatch: expected %0d, got %0d", oldest_answer.status,
                      rsp_chan.status);
               error_count++;
            end
            if (rsp_chan.found_value !== oldest_answer.found_value) begin
               $error("found_value mismatch: expected %h, got %h",
                      oldest_answer.found_value, rsp_chan.found_value);
               error_count++;
            end
            if (rsp_chan.slot !== oldest_answer.slot) begin
               $error("slot mismatch: expected %0d, got %0d", oldest_answer.slot,
                      rsp_chan.slot);
               error_count++;
            end
         end
      end
      if (!idling_on) begin
         rsp_hold = 0;
         rsp_chan.ready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_chan.ready <= (rsp_hold == 0);
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_hold = $urandom_range(1, 10);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   initial begin
      req_chan.valid        = 1'b0;
      req_chan.req_type     = REQ_INSERT;
      req_chan.key          = '0;
      req_chan.value        = '0;
      csr_chan.valid        = 1'b0;
      csr_chan.replace_mode = 1'b0;
      shadow_used    = '0;
      shadow_replace = 1'b0;
      foreach (status_seen[i]) status_seen[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      idling_on = 1'b1;
      test_fill_to_capacity();
      test_replace_mode();
      for (int p = 0; p < 6; p++)
         test_random_traffic(220, p[0], $urandom_range(0, 3) != 0);
      test_random_traffic(220, 1'b0, 1'b0);

      wait_for_drain();
      repeat (40) @(posedge clock);
      $display("Covered %0d requests with %0d mode writes, including wrap-around probes,",
               request_count, mode_writes);
      $display("a full table and broken chains: added %0d, replaced %0d, full %0d,",
               status_seen[ST_ADDED], status_seen[ST_REPLACED], status_seen[ST_FULL]);
      $display("found %0d, not found %0d, deleted %0d, bad key %0d.",
               status_seen[ST_FOUND], status_seen[ST_NOT_FOUND], status_seen[ST_DELETED],
               status_seen[ST_BAD_KEY]);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d responses outstanding.", pending_answers.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
